[src/ssag_pkg.sv]
// Shared types, constants and controller/datapath interface structs of the spiral scan generator.
package ssag_pkg;

  // Default and field widths
  localparam int MAX_DIM_DEF = 128;
  localparam int DIM_CFG_W   = 8;
  localparam int POS_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd3;

  // Walk directions
  localparam logic [1:0] DIR_EAST  = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_WEST  = 2'd2;
  localparam logic [1:0] DIR_NORTH = 2'd3;

  typedef struct packed {
    logic restart;   // latch grid, reset walk, emit start cell
    logic step;      // advance the walk by one position
    logic exhaust;   // repeat last cell with exhausted flag
    logic load_out;  // move result into the output register
  } ssag_cmd_t;

  typedef struct packed {
    logic first;     // no cell emitted since reset
    logic done;      // every cell of the grid emitted
    logic hit;       // the step being taken lands inside the grid
  } ssag_status_t;

endpackage

[src/ssag_ctrl.sv]
// Controller state machine of the spiral scan generator.
module ssag_ctrl
  import ssag_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_restart,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  ssag_status_t status,
  output ssag_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_restart || status.first) begin
            cmd.restart = 1'b1;
            state_nxt   = S_EMIT;
          end else if (status.done) begin
            cmd.exhaust = 1'b1;
            state_nxt   = S_EMIT;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (status.hit) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/ssag_dp.sv]
// Datapath of the spiral scan generator: config registers, walk position, counters, output register.
module ssag_dp
  import ssag_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_CFG_W-1:0] cfg_data,
  input  ssag_cmd_t            cmd,
  output ssag_status_t         status,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic                 out_last,
  output logic                 out_exh
);

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int WW   = $clog2(MAX_DIM) + 3;
  localparam int LW   = $clog2(MAX_DIM) + 2;
  localparam int CW   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int CMPW = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
  localparam int SW   = (DW > POS_W) ? DW : POS_W;

  logic [DIM_CFG_W-1:0] grid_rows_r, grid_cols_r;
  logic [POS_W-1:0]     start_row_r, start_col_r;

  logic [WW-1:0] walk_row_r, walk_col_r;
  logic [LW-1:0] leg_len_r, leg_prog_r;
  logic [1:0]    leg_dir_r;
  logic [CW-1:0] cells_r, total_r;
  logic [DW-1:0] lat_rows_r, lat_cols_r;
  logic [POS_W-1:0] prev_row_r, prev_col_r;
  logic             res_last_r, res_exh_r;
  logic [POS_W-1:0] out_row_r, out_col_r;
  logic             out_last_r, out_exh_r;

  logic [DW-1:0]   rows_clamp, cols_clamp;
  logic [CMPW-1:0] rows_ext, cols_ext, rows_sat, cols_sat;
  logic [SW-1:0]   srow_sat, scol_sat;
  logic [WW-1:0]   row_step, col_step;
  logic [LW-1:0]   prog_inc;
  logic            leg_wrap, in_grid;
  logic [CW-1:0]   cells_inc;
  logic [2*DW-1:0] grid_prod;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DIM_CFG_W'(1);
      grid_cols_r <= DIM_CFG_W'(1);
      start_row_r <= '0;
      start_col_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_data;
        REG_GRID_COLS: grid_cols_r <= cfg_data;
        REG_START_ROW: start_row_r <= cfg_data[POS_W-1:0];
        REG_START_COL: start_col_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size to 1..MAX_DIM, saturate start into the grid
  always_comb begin
    rows_ext = CMPW'(grid_rows_r);
    cols_ext = CMPW'(grid_cols_r);
    if (rows_ext == '0) begin
      rows_sat = CMPW'(1);
    end else if (rows_ext > CMPW'(MAX_DIM)) begin
      rows_sat = CMPW'(MAX_DIM);
    end else begin
      rows_sat = rows_ext;
    end
    if (cols_ext == '0) begin
      cols_sat = CMPW'(1);
    end else if (cols_ext > CMPW'(MAX_DIM)) begin
      cols_sat = CMPW'(MAX_DIM);
    end else begin
      cols_sat = cols_ext;
    end
    rows_clamp = DW'(rows_sat);
    cols_clamp = DW'(cols_sat);
    srow_sat = (SW'(start_row_r) < SW'(rows_clamp)) ? SW'(start_row_r)
                                                     : SW'(rows_clamp) - SW'(1);
    scol_sat = (SW'(start_col_r) < SW'(cols_clamp)) ? SW'(start_col_r)
                                                     : SW'(cols_clamp) - SW'(1);
  end

  // One spiral step
  always_comb begin
    row_step = walk_row_r;
    col_step = walk_col_r;
    case (leg_dir_r)
      DIR_EAST:  col_step = walk_col_r + WW'(1);
      DIR_SOUTH: row_step = walk_row_r + WW'(1);
      DIR_WEST:  col_step = walk_col_r - WW'(1);
      DIR_NORTH: row_step = walk_row_r - WW'(1);
      default:   row_step = walk_row_r;
    endcase
    prog_inc = leg_prog_r + LW'(1);
    leg_wrap = (prog_inc >= leg_len_r);
    // Sign bit clear means non-negative, so an unsigned compare suffices
    in_grid  = !row_step[WW-1] && !col_step[WW-1] &&
               (row_step < WW'(lat_rows_r)) && (col_step < WW'(lat_cols_r));
  end

  assign cells_inc    = cells_r + CW'(1);
  assign grid_prod    = lat_rows_r * lat_cols_r;
  assign status.first = (cells_r == '0);
  assign status.done  = (cells_r >= total_r);
  assign status.hit   = in_grid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= '0;
    end else if (cmd.restart) begin
      cells_r <= CW'(1);
    end else if (cmd.step && in_grid) begin
      cells_r <= cells_inc;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= CW'(grid_prod);
    if (cmd.restart) begin
      lat_rows_r <= rows_clamp;
      lat_cols_r <= cols_clamp;
      walk_row_r <= WW'(srow_sat);
      walk_col_r <= WW'(scol_sat);
      leg_len_r  <= LW'(1);
      leg_prog_r <= '0;
      leg_dir_r  <= DIR_EAST;
      prev_row_r <= srow_sat[POS_W-1:0];
      prev_col_r <= scol_sat[POS_W-1:0];
      res_last_r <= (rows_clamp == DW'(1)) && (cols_clamp == DW'(1));
      res_exh_r  <= 1'b0;
    end else if (cmd.step) begin
      walk_row_r <= row_step;
      walk_col_r <= col_step;
      if (leg_wrap) begin
        leg_prog_r <= '0;
        leg_dir_r  <= leg_dir_r + 2'd1;
        if (leg_dir_r[0]) begin
          leg_len_r <= leg_len_r + LW'(1);
        end
      end else begin
        leg_prog_r <= prog_inc;
      end
      if (in_grid) begin
        prev_row_r <= row_step[POS_W-1:0];
        prev_col_r <= col_step[POS_W-1:0];
        res_last_r <= (cells_inc == total_r);
        res_exh_r  <= 1'b0;
      end
    end else if (cmd.exhaust) begin
      res_last_r <= 1'b1;
      res_exh_r  <= 1'b1;
    end
    if (cmd.load_out) begin
      out_row_r  <= prev_row_r;
      out_col_r  <= prev_col_r;
      out_last_r <= res_last_r;
      out_exh_r  <= res_exh_r;
    end
  end

  assign out_row  = out_row_r;
  assign out_col  = out_col_r;
  assign out_last = out_last_r;
  assign out_exh  = out_exh_r;

endmodule

[src/spiral_scan_address_generator_core.sv]
// Top level of the outward square-spiral scan address generator.
// Usage:
//   Input stream (in_*): one request per transfer; in_tdata[0] = restart.
//   A restart request latches the grid size and start cell from the
//   configuration registers and returns the start cell. An advance request
//   returns the next in-grid cell of the outward spiral; once every cell is
//   out, advance requests repeat the last cell with tuser (exhausted) set.
//   Output stream (out_*): one result per request, tdata = {col, row},
//   tlast = final cell of the grid, tuser = exhausted.
//   Config port (cfg_*): always ready; write only while the block is idle.
// Timing:
//   A request is taken in the idle state, then the walk unit advances one
//   spiral position per cycle until it lands in the grid. A restart or an
//   exhausted request goes from idle straight to the emit state; an advance
//   passes through the walk state, whose steps include skipped out-of-grid
//   positions. The emit state moves the result into the output register.
// Reset and stall:
//   rst_n (synchronous, active low) clears the cell count and restores grid 1x1,
//   start 0,0. A stalled receiver holds the result in the output register;
//   one further request is still taken and worked, then waits for the slot.
module spiral_scan_address_generator_core
  import ssag_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [6:0] cell_row, [13:7] cell_col, [15:14] zero
  output logic                  out_tlast,  // last_cell
  output logic                  out_tuser,  // [0] exhausted
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_CFG_W-1:0]  cfg_data
);

  ssag_cmd_t        cmd;
  ssag_status_t     status;
  logic [POS_W-1:0] cell_row, cell_col;

  // Config writes are taken in any cycle
  assign cfg_ready = 1'b1;

  ssag_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_restart (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ssag_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_row   (cell_row),
    .out_col   (cell_col),
    .out_last  (out_tlast),
    .out_exh   (out_tuser)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {(OUT_DATA_W - 2*POS_W)'(0), cell_col, cell_row};

endmodule

[src/ssag_checker.sv]
// Port-level checker of the spiral scan generator and its bind.
module ssag_checker
  import ssag_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Exhausted result always marks the final cell
  a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("exhausted result without last flag");

  // One request in work at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  // Reset drops the output
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind spiral_scan_address_generator_core ssag_checker u_ssag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
